### hdl/aop_pkg.sv
`timescale 1ns / 1ps

package aop_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 32;
  localparam int unsigned COORD_BITS_DEF  = 16;

  localparam int unsigned KIND_W = 3;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned STAT_W = 3;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RM    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLR   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SCAN  = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_OCCUPIED = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_HIT      = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NONE     = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_e;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic              adv;
    logic              wr;
    logic              rm;
    logic              clr;
    logic              scan;
    logic [SLOT_W-1:0] wslot;
    logic [SLOT_W-1:0] sslot;
  } ctl_t;

  // token handed from one cell to the next
  typedef struct packed {
    logic tok;
    logic armed;
  } link_t;

endpackage

### hdl/aop_in_if.sv
`timescale 1ns / 1ps

interface aop_in_if
  import aop_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) ();

  logic                         valid;
  logic                         ready;
  logic        [KIND_W-1:0]     kind;
  logic        [SLOT_W-1:0]     slot;
  logic signed [COORD_BITS-1:0] min_x;
  logic signed [COORD_BITS-1:0] min_y;
  logic signed [COORD_BITS-1:0] min_z;
  logic signed [COORD_BITS-1:0] max_x;
  logic signed [COORD_BITS-1:0] max_y;
  logic signed [COORD_BITS-1:0] max_z;

  modport source (
    output valid, kind, slot, min_x, min_y, min_z, max_x, max_y, max_z,
    input  ready
  );

  modport sink (
    input  valid, kind, slot, min_x, min_y, min_z, max_x, max_y, max_z,
    output ready
  );

endinterface

### hdl/aop_out_if.sv
`timescale 1ns / 1ps

interface aop_out_if
  import aop_pkg::*;
();

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] partner_slot;
  logic              last;

  modport source (
    output valid, status, partner_slot, last,
    input  ready
  );

  modport sink (
    input  valid, status, partner_slot, last,
    output ready
  );

endinterface

### hdl/aop_cell.sv
`timescale 1ns / 1ps

module aop_cell
  import aop_pkg::*;
#(
  parameter int unsigned INDEX      = 0,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctl_t                    ctl_i,
  input  logic [3*COORD_BITS-1:0] wlo_i,
  input  logic [3*COORD_BITS-1:0] whi_i,
  input  link_t                   link_i,
  input  logic [3*COORD_BITS-1:0] plo_i,
  input  logic [3*COORD_BITS-1:0] phi_i,
  output link_t                   link_o,
  output logic [3*COORD_BITS-1:0] plo_o,
  output logic [3*COORD_BITS-1:0] phi_o,
  output logic                    hit_o,
  output logic                    used_o
);

  localparam logic [31:0] MY_SLOT = 32'(INDEX);

  logic                    used_q;
  logic [3*COORD_BITS-1:0] lo_q, hi_q;
  link_t                   link_q;
  logic [3*COORD_BITS-1:0] plo_q, phi_q;
  logic                    wsel, target, meet;

  assign wsel   = (32'(ctl_i.wslot) == MY_SLOT);
  assign target = ctl_i.scan && (32'(ctl_i.sslot) == MY_SLOT) && link_q.tok;

  always_comb begin
    meet = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (($signed(plo_q[a*COORD_BITS +: COORD_BITS]) >
           $signed(hi_q[a*COORD_BITS +: COORD_BITS])) ||
          ($signed(lo_q[a*COORD_BITS +: COORD_BITS]) >
           $signed(phi_q[a*COORD_BITS +: COORD_BITS]))) begin
        meet = 1'b0;
      end
    end
  end

  assign hit_o  = link_q.tok && link_q.armed && used_q && meet;
  assign used_o = used_q;

  // the scanned slot swaps in its own box and arms every later cell
  assign link_o.tok   = link_q.tok;
  assign link_o.armed = link_q.armed || target;
  assign plo_o        = target ? lo_q : plo_q;
  assign phi_o        = target ? hi_q : phi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      link_q <= '0;
    end else begin
      if (ctl_i.clr) begin
        used_q <= 1'b0;
      end else if (ctl_i.wr && wsel) begin
        used_q <= 1'b1;
      end else if (ctl_i.rm && wsel) begin
        used_q <= 1'b0;
      end
      if (ctl_i.adv) begin
        link_q <= link_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr && wsel) begin
      lo_q <= wlo_i;
      hi_q <= whi_i;
    end
    if (ctl_i.adv) begin
      plo_q <= plo_i;
      phi_q <= phi_i;
    end
  end

endmodule

### hdl/aop_seq.sv
`timescale 1ns / 1ps

module aop_seq
  import aop_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  aop_in_if.sink                 req_i,
  aop_out_if.source              rsp_o,
  input  logic [MAX_ENTRIES-1:0] used_i,
  input  logic                   hit_i,
  input  logic                   tail_tok_i,
  output ctl_t                   ctl_o,
  output link_t                  launch_o
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  pos_q;
  logic              pend_v_q;
  logic [SLOT_W-1:0] pend_slot_q;
  logic [STAT_W-1:0] fin_q, fin_d;
  logic              scan_q;
  logic [SLOT_W-1:0] scan_slot_q;
  logic              out_v_q;
  logic [STAT_W-1:0] out_stat_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic              out_last_q;

  logic accept, in_range, used_rd, out_free, stall;
  logic walk_go, is_query, is_scan, do_wr, do_rm, do_clr;
  logic load_mid, load_fin;

  assign accept   = req_i.valid && req_i.ready;
  assign in_range = 32'(req_i.slot) < 32'(MAX_ENTRIES);
  assign used_rd  = in_range && used_i[IDX_W'(req_i.slot)];
  assign out_free = !out_v_q || rsp_o.ready;
  assign stall    = (state_q == ST_WALK) && hit_i && pend_v_q && !out_free;

  // decode the request
  always_comb begin
    walk_go  = 1'b0;
    is_query = 1'b0;
    is_scan  = 1'b0;
    do_wr    = 1'b0;
    do_rm    = 1'b0;
    do_clr   = 1'b0;
    fin_d    = STAT_OK;
    unique case (req_i.kind)
      KIND_ADD: begin
        if (used_rd || !in_range) begin
          fin_d = STAT_OCCUPIED;
        end else begin
          do_wr = 1'b1;
        end
      end
      KIND_RM: begin
        if (used_rd) begin
          do_rm = 1'b1;
        end else begin
          fin_d = STAT_EMPTY;
        end
      end
      KIND_CLR: begin
        do_clr = 1'b1;
      end
      KIND_QUERY: begin
        walk_go  = 1'b1;
        is_query = 1'b1;
        fin_d    = STAT_NONE;
      end
      KIND_SCAN: begin
        if (used_rd) begin
          walk_go = 1'b1;
          is_scan = 1'b1;
          fin_d   = STAT_NONE;
        end else begin
          fin_d = STAT_EMPTY;
        end
      end
      default: begin
        fin_d = STAT_OK;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = walk_go ? ST_WALK : ST_DONE;
        end
      end
      ST_WALK: begin
        if (!stall && tail_tok_i) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_i.ready    = (state_q == ST_IDLE);
    load_mid       = (state_q == ST_WALK) && hit_i && pend_v_q && out_free;
    load_fin       = (state_q == ST_DONE) && out_free;
    ctl_o.adv      = !stall;
    ctl_o.wr       = accept && do_wr;
    ctl_o.rm       = accept && do_rm;
    ctl_o.clr      = accept && do_clr;
    ctl_o.scan     = scan_q;
    ctl_o.wslot    = req_i.slot;
    ctl_o.sslot    = scan_slot_q;
    launch_o.tok   = accept && walk_go;
    launch_o.armed = accept && is_query;
  end

  assign rsp_o.valid        = out_v_q;
  assign rsp_o.status       = out_stat_q;
  assign rsp_o.partner_slot = out_slot_q;
  assign rsp_o.last         = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pos_q    <= '0;
      pend_v_q <= 1'b0;
      scan_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        pos_q    <= '0;
        pend_v_q <= 1'b0;
        scan_q   <= is_scan;
      end else if (state_q == ST_WALK && !stall) begin
        pos_q <= pos_q + IDX_W'(1);
        if (hit_i) begin
          pend_v_q <= 1'b1;
        end
      end else if (load_fin) begin
        pend_v_q <= 1'b0;
      end
      if (load_mid || load_fin) begin
        out_v_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fin_q       <= fin_d;
      scan_slot_q <= req_i.slot;
    end
    if (state_q == ST_WALK && !stall && hit_i) begin
      pend_slot_q <= SLOT_W'(pos_q);
    end
    if (load_mid) begin
      out_stat_q <= STAT_HIT;
      out_slot_q <= pend_slot_q;
      out_last_q <= 1'b0;
    end else if (load_fin) begin
      out_stat_q <= pend_v_q ? STAT_HIT : fin_q;
      out_slot_q <= pend_v_q ? pend_slot_q : '0;
      out_last_q <= 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
    else $error("sequencer stayed idle after a request");

  a_hit_only_walking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_i |-> state_q == ST_WALK)
    else $error("cell hit outside of a walk");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && stall) |=> ($stable(pos_q) && state_q == ST_WALK))
    else $error("walk moved while stalled");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_v_q)
    else $error("pending hit left over in idle");
`endif

endmodule

### hdl/aabb_overlap_pair_finder_top.sv
// Brute-force box overlap finder for up to MAX_ENTRIES axis-aligned 3D boxes held in a row of
// cells, one slot per cell. A request adds a box to a slot, removes a slot, clears all slots,
// tests a given box against every stored box, or tests a stored slot against all higher slots.
// Add, remove, clear and unknown kinds pass through the done state to the output register and
// answer with one result. Query and scan launch a token that steps through the cell row one
// cell per clock while the result side does not stall. Overlaps come out in increasing slot
// order, touching faces count, and the final result of every request carries last. One request
// is worked at a time; a new one is taken as soon as the previous final result sits in the
// output register, even before it is taken. The box stores have no reset value; only slot use
// bits and token links do.
`timescale 1ns / 1ps

module aabb_overlap_pair_finder_top
  import aop_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  aop_in_if.sink    req_i,
  aop_out_if.source rsp_o
);

  ctl_t                    ctl;
  link_t                   link   [MAX_ENTRIES+1];
  logic [3*COORD_BITS-1:0] plo    [MAX_ENTRIES+1];
  logic [3*COORD_BITS-1:0] phi    [MAX_ENTRIES+1];
  logic [MAX_ENTRIES-1:0]  hit_vec;
  logic [MAX_ENTRIES-1:0]  used_vec;
  logic [MAX_ENTRIES-1:0]  tok_vec;
  logic [3*COORD_BITS-1:0] req_lo, req_hi;

  // pack the request box, x in the low bits
  assign req_lo = {req_i.min_z, req_i.min_y, req_i.min_x};
  assign req_hi = {req_i.max_z, req_i.max_y, req_i.max_x};

  // the query box enters the head of the row with the token
  assign plo[0] = req_lo;
  assign phi[0] = req_hi;

  aop_seq #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .rsp_o      (rsp_o),
    .used_i     (used_vec),
    .hit_i      (|hit_vec),
    .tail_tok_i (link[MAX_ENTRIES].tok),
    .ctl_o      (ctl),
    .launch_o   (link[0])
  );

  // one cell per slot; each hands token and probe box to the next
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    aop_cell #(
      .INDEX      (g),
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .wlo_i  (req_lo),
      .whi_i  (req_hi),
      .link_i (link[g]),
      .plo_i  (plo[g]),
      .phi_i  (phi[g]),
      .link_o (link[g+1]),
      .plo_o  (plo[g+1]),
      .phi_o  (phi[g+1]),
      .hit_o  (hit_vec[g]),
      .used_o (used_vec[g])
    );
    assign tok_vec[g] = link[g+1].tok;
  end

`ifndef NO_ASSERTIONS
  a_single_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec) && (!link[0].tok || (tok_vec == '0)))
    else $error("more than one token in the cell row");
`endif

endmodule
